// File: sv/rycc_pkg.sv
// Shared constants and types of the BT.601 RGB / YPbPr converter.
// Depends on nothing; used by rgb_ypbpr_color_converter.
`default_nettype none

package rycc_pkg;

    localparam int CHAN_W     = 16;   // channel sample and output width
    localparam int DIFF_W     = 17;   // signed Y/Pb/Pr input width
    localparam int FRAC_BITS  = 15;   // fraction bits of Y/Pb/Pr (32768 = 1.0)
    localparam int COEF_BITS  = 16;   // fraction bits of the coefficients

    localparam int COEF_W     = 18;   // signed width of the inverse coefficients
    localparam int PROD_W     = DIFF_W + COEF_W;        // 35
    localparam int LIN_W      = PROD_W + 1;             // 36, inverse R/G/B sums
    localparam int FPROD_W    = 2 * CHAN_W;             // 32, forward products
    localparam int ACC_W      = FPROD_W + 2;            // 34, forward signed sums
    localparam int NUM_W      = 2 * CHAN_W;             // 32, divider numerator
    localparam int QUO_W      = CHAN_W;                 // 16 quotient bits
    localparam int REM_W      = CHAN_W + 1;             // remainder < 2 * max
    localparam int DPROD_W    = FRAC_BITS + COEF_BITS + 1 + CHAN_W;  // 48
    localparam int DENORM_SH  = FRAC_BITS + COEF_BITS;  // 31

    localparam int DIV_STAGES = QUO_W;                  // one quotient bit a stage
    localparam int LATENCY    = 4 + DIV_STAGES + 1;

    localparam logic ACT_FORWARD = 1'b0;   // RGB to YPbPr
    localparam logic ACT_INVERSE = 1'b1;   // YPbPr to RGB

    localparam logic [CHAN_W-1:0] MAX_VALUE_RESET = 16'd255;

    // forward coefficients, magnitudes; the 0.5 terms are a shift by 15
    localparam logic [CHAN_W-1:0] CY_R  = 16'd19595;
    localparam logic [CHAN_W-1:0] CY_G  = 16'd38470;
    localparam logic [CHAN_W-1:0] CY_B  = 16'd7471;
    localparam logic [CHAN_W-1:0] CPB_R = 16'd11058;
    localparam logic [CHAN_W-1:0] CPB_G = 16'd21710;
    localparam logic [CHAN_W-1:0] CPR_G = 16'd27439;
    localparam logic [CHAN_W-1:0] CPR_B = 16'd5329;
    localparam int                HALF_SH = COEF_BITS - 1;

    // inverse coefficients
    localparam logic signed [COEF_W-1:0] CI_R_PR = 18'sd91881;
    localparam logic signed [COEF_W-1:0] CI_G_PB = 18'sd22554;
    localparam logic signed [COEF_W-1:0] CI_G_PR = 18'sd46802;
    localparam logic signed [COEF_W-1:0] CI_B_PB = 18'sd116130;

    localparam logic [LIN_W-1:0]     DENORM_ONE  = LIN_W'(1) << DENORM_SH;
    localparam logic [DPROD_W:0]     DENORM_HALF = (DPROD_W + 1)'(1) << (DENORM_SH - 1);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  low;    // numerator bits not yet brought down
        logic [QUO_W-1:0]  quo;
        logic              neg;
    } div_lane_t;

    typedef struct packed {
        logic                        action;
        div_lane_t [2:0]             lane;   // 0 = Y, 1 = Pb, 2 = Pr
        logic [2:0][CHAN_W-1:0]      rgb;    // inverse results, 0 = R, 1 = G, 2 = B
    } div_stage_t;

endpackage

`default_nettype wire

// File: sv/rgb_ypbpr_color_converter.sv
// BT.601 RGB <-> YPbPr converter, one pixel per clock, fully pipelined.
// Depends on rycc_pkg (constants, coefficient values, divider stage types).
//
// Usage:
//   A pixel word is taken at a rising edge with start high and busy low. busy
//   never rises: the pipeline takes a new word in every cycle. action selects
//   RGB to YPbPr (forward) or YPbPr to RGB (inverse).
//   Each result word appears with done high for exactly one cycle, in the
//   order the words went in. Fields of the mode not used read as zero.
//   The forward path sets the pipeline depth: four stages of clamp, multiply,
//   sum and magnitude, then a restoring divider by 2 * max_value that resolves
//   one quotient bit per stage over 16 stages, then the output register.
//   Inverse words travel along the same stages so order is kept.
//   Throughput: one word per cycle.
//   max_value is written through cfg_we / cfg_wdata. The user must write it
//   only while no word is in flight; the block does not enforce this. A
//   written zero acts as one. Reset sets it to 255 and empties the pipeline,
//   dropping words in flight; the receiver cannot stall the output.
`default_nettype none

module rgb_ypbpr_color_converter (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    action,
    input  logic        [rycc_pkg::CHAN_W-1:0]      in_red,
    input  logic        [rycc_pkg::CHAN_W-1:0]      in_green,
    input  logic        [rycc_pkg::CHAN_W-1:0]      in_blue,
    input  logic signed [rycc_pkg::DIFF_W-1:0]      in_luma,
    input  logic signed [rycc_pkg::DIFF_W-1:0]      in_blue_diff,
    input  logic signed [rycc_pkg::DIFF_W-1:0]      in_red_diff,
    input  logic                                    cfg_we,
    input  logic        [rycc_pkg::CHAN_W-1:0]      cfg_wdata,
    output logic                                    done,
    output logic        [rycc_pkg::CHAN_W-1:0]      out_red,
    output logic        [rycc_pkg::CHAN_W-1:0]      out_green,
    output logic        [rycc_pkg::CHAN_W-1:0]      out_blue,
    output logic        [rycc_pkg::CHAN_W-1:0]      out_luma,
    output logic signed [rycc_pkg::CHAN_W-1:0]      out_blue_diff,
    output logic signed [rycc_pkg::CHAN_W-1:0]      out_red_diff
);

    localparam int CW  = rycc_pkg::CHAN_W;
    localparam int DS  = rycc_pkg::DIV_STAGES;
    localparam int LAT = rycc_pkg::LATENCY;

    // ---------------------------------------------------------------
    // control
    logic [CW-1:0]   max_value_reg, max_value_next;
    logic [LAT-1:0]  valid_reg, valid_next;
    logic            accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        max_value_next = max_value_reg;
        if (cfg_we)
        begin
            max_value_next = (cfg_wdata == '0) ? CW'(1) : cfg_wdata;
        end
        valid_next = {valid_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= rycc_pkg::MAX_VALUE_RESET;
            valid_reg     <= '0;
        end
        else
        begin
            max_value_reg <= max_value_next;
            valid_reg     <= valid_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: clamp samples, inverse coefficient products
    logic                                       s1_action_reg, s1_action_next;
    logic        [CW-1:0]                       s1_red_reg, s1_red_next;
    logic        [CW-1:0]                       s1_green_reg, s1_green_next;
    logic        [CW-1:0]                       s1_blue_reg, s1_blue_next;
    logic signed [rycc_pkg::DIFF_W-1:0]         s1_luma_reg, s1_luma_next;
    logic signed [rycc_pkg::PROD_W-1:0]         s1_r_pr_reg, s1_r_pr_next;
    logic signed [rycc_pkg::PROD_W-1:0]         s1_g_pb_reg, s1_g_pb_next;
    logic signed [rycc_pkg::PROD_W-1:0]         s1_g_pr_reg, s1_g_pr_next;
    logic signed [rycc_pkg::PROD_W-1:0]         s1_b_pb_reg, s1_b_pb_next;

    always_comb
    begin
        s1_action_next = action;
        s1_red_next    = (in_red   > max_value_reg) ? max_value_reg : in_red;
        s1_green_next  = (in_green > max_value_reg) ? max_value_reg : in_green;
        s1_blue_next   = (in_blue  > max_value_reg) ? max_value_reg : in_blue;
        s1_luma_next   = in_luma;
        s1_r_pr_next   = rycc_pkg::PROD_W'(in_red_diff)
                       * rycc_pkg::PROD_W'(rycc_pkg::CI_R_PR);
        s1_g_pb_next   = rycc_pkg::PROD_W'(in_blue_diff)
                       * rycc_pkg::PROD_W'(rycc_pkg::CI_G_PB);
        s1_g_pr_next   = rycc_pkg::PROD_W'(in_red_diff)
                       * rycc_pkg::PROD_W'(rycc_pkg::CI_G_PR);
        s1_b_pb_next   = rycc_pkg::PROD_W'(in_blue_diff)
                       * rycc_pkg::PROD_W'(rycc_pkg::CI_B_PB);
    end

    // ---------------------------------------------------------------
    // stage 2: forward coefficient products, inverse sums
    localparam int FPW = rycc_pkg::FPROD_W;
    localparam int LW  = rycc_pkg::LIN_W;

    logic                   s2_action_reg, s2_action_next;
    logic [CW-1:0]          s2_red_reg, s2_red_next;
    logic [CW-1:0]          s2_blue_reg, s2_blue_next;
    logic [FPW-1:0]         s2_y_r_reg, s2_y_r_next;
    logic [FPW-1:0]         s2_y_g_reg, s2_y_g_next;
    logic [FPW-1:0]         s2_y_b_reg, s2_y_b_next;
    logic [FPW-1:0]         s2_pb_r_reg, s2_pb_r_next;
    logic [FPW-1:0]         s2_pb_g_reg, s2_pb_g_next;
    logic [FPW-1:0]         s2_pr_g_reg, s2_pr_g_next;
    logic [FPW-1:0]         s2_pr_b_reg, s2_pr_b_next;
    logic [2:0][LW-1:0]     s2_lin_reg, s2_lin_next;
    logic [LW-1:0]          luma_scaled;

    always_comb
    begin
        s2_action_next = s1_action_reg;
        s2_red_next    = s1_red_reg;
        s2_blue_next   = s1_blue_reg;
        s2_y_r_next    = FPW'(s1_red_reg)   * FPW'(rycc_pkg::CY_R);
        s2_y_g_next    = FPW'(s1_green_reg) * FPW'(rycc_pkg::CY_G);
        s2_y_b_next    = FPW'(s1_blue_reg)  * FPW'(rycc_pkg::CY_B);
        s2_pb_r_next   = FPW'(s1_red_reg)   * FPW'(rycc_pkg::CPB_R);
        s2_pb_g_next   = FPW'(s1_green_reg) * FPW'(rycc_pkg::CPB_G);
        s2_pr_g_next   = FPW'(s1_green_reg) * FPW'(rycc_pkg::CPR_G);
        s2_pr_b_next   = FPW'(s1_blue_reg)  * FPW'(rycc_pkg::CPR_B);

        luma_scaled    = LW'(s1_luma_reg) << rycc_pkg::COEF_BITS;
        s2_lin_next[0] = luma_scaled + LW'(s1_r_pr_reg);
        s2_lin_next[1] = luma_scaled - LW'(s1_g_pb_reg) - LW'(s1_g_pr_reg);
        s2_lin_next[2] = luma_scaled + LW'(s1_b_pb_reg);
    end

    // ---------------------------------------------------------------
    // stage 3: forward sums, inverse clamp flags and scale by max_value
    localparam int AW  = rycc_pkg::ACC_W;
    localparam int DPW = rycc_pkg::DPROD_W;

    logic                   s3_action_reg, s3_action_next;
    logic [2:0][AW-1:0]     s3_acc_reg, s3_acc_next;     // two's complement
    logic [2:0]             s3_neg_reg, s3_neg_next;
    logic [2:0]             s3_over_reg, s3_over_next;
    logic [2:0][DPW-1:0]    s3_prod_reg, s3_prod_next;

    always_comb
    begin
        s3_action_next = s2_action_reg;
        s3_acc_next[0] = AW'(s2_y_r_reg) + AW'(s2_y_g_reg) + AW'(s2_y_b_reg);
        s3_acc_next[1] = (AW'(s2_blue_reg) << rycc_pkg::HALF_SH)
                       - AW'(s2_pb_r_reg) - AW'(s2_pb_g_reg);
        s3_acc_next[2] = (AW'(s2_red_reg) << rycc_pkg::HALF_SH)
                       - AW'(s2_pr_g_reg) - AW'(s2_pr_b_reg);
        for (int i = 0; i < 3; i++)
        begin
            s3_neg_next[i]  = s2_lin_reg[i][LW-1];
            s3_over_next[i] = !s2_lin_reg[i][LW-1] && (s2_lin_reg[i] > rycc_pkg::DENORM_ONE);
            s3_prod_next[i] = DPW'(s2_lin_reg[i][rycc_pkg::DENORM_SH:0]) * DPW'(max_value_reg);
        end
    end

    // ---------------------------------------------------------------
    // stage 4 (divider entry): forward magnitudes, inverse rounding.
    // With 15 fraction bits over 16-bit coefficients the rounded quotient
    // is floor((|acc| + max) / (2 * max)), ties away from zero.
    localparam int NW = rycc_pkg::NUM_W;

    rycc_pkg::div_stage_t   div_reg  [0:DS];
    rycc_pkg::div_stage_t   div_next [0:DS];
    logic [2:0][AW-1:0]     acc_mag;
    logic [2:0][NW-1:0]     numer;
    logic [2:0][DPW:0]      rounded;
    logic [2:0][rycc_pkg::REM_W:0]  trial;
    logic [2:0]             q_bit;
    logic [rycc_pkg::QUO_W:0]       divisor;

    always_comb
    begin
        div_next[0].action = s3_action_reg;
        for (int i = 0; i < 3; i++)
        begin
            acc_mag[i] = s3_acc_reg[i][AW-1] ? (AW'(0) - s3_acc_reg[i]) : s3_acc_reg[i];
            numer[i]   = NW'(acc_mag[i] + AW'(max_value_reg));
            div_next[0].lane[i].rem = rycc_pkg::REM_W'(numer[i][NW-1:rycc_pkg::QUO_W]);
            div_next[0].lane[i].low = numer[i][rycc_pkg::QUO_W-1:0];
            div_next[0].lane[i].quo = '0;
            div_next[0].lane[i].neg = s3_acc_reg[i][AW-1];

            rounded[i] = (DPW + 1)'(s3_prod_reg[i]) + rycc_pkg::DENORM_HALF;
            if (s3_neg_reg[i])
            begin
                div_next[0].rgb[i] = '0;
            end
            else if (s3_over_reg[i])
            begin
                div_next[0].rgb[i] = max_value_reg;
            end
            else
            begin
                div_next[0].rgb[i] = rounded[i][rycc_pkg::DENORM_SH +: CW];
            end
        end

        // restoring divide by 2 * max, one quotient bit per stage;
        // the partial remainder stays below 2 * max, the trial below 4 * max
        divisor = {max_value_reg, 1'b0};
        trial   = '0;
        q_bit   = '0;
        for (int k = 1; k <= DS; k++)
        begin
            div_next[k] = div_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {div_reg[k-1].lane[i].rem, div_reg[k-1].lane[i].low[rycc_pkg::QUO_W-1]};
                q_bit[i] = (trial[i] >= {1'b0, divisor});
                div_next[k].lane[i].rem = q_bit[i]
                                        ? rycc_pkg::REM_W'(trial[i] - {1'b0, divisor})
                                        : rycc_pkg::REM_W'(trial[i]);
                div_next[k].lane[i].low = {div_reg[k-1].lane[i].low[rycc_pkg::QUO_W-2:0], 1'b0};
                div_next[k].lane[i].quo = {div_reg[k-1].lane[i].quo[rycc_pkg::QUO_W-2:0], q_bit[i]};
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    logic [CW-1:0]  out_red_reg, out_red_next;
    logic [CW-1:0]  out_green_reg, out_green_next;
    logic [CW-1:0]  out_blue_reg, out_blue_next;
    logic [CW-1:0]  out_luma_reg, out_luma_next;
    logic [CW-1:0]  out_pb_reg, out_pb_next;
    logic [CW-1:0]  out_pr_reg, out_pr_next;

    always_comb
    begin
        out_red_next   = '0;
        out_green_next = '0;
        out_blue_next  = '0;
        out_luma_next  = '0;
        out_pb_next    = '0;
        out_pr_next    = '0;
        case (div_reg[DS].action)
            rycc_pkg::ACT_FORWARD:
            begin
                out_luma_next = div_reg[DS].lane[0].quo;
                out_pb_next   = div_reg[DS].lane[1].neg
                              ? CW'(0) - div_reg[DS].lane[1].quo : div_reg[DS].lane[1].quo;
                out_pr_next   = div_reg[DS].lane[2].neg
                              ? CW'(0) - div_reg[DS].lane[2].quo : div_reg[DS].lane[2].quo;
            end
            rycc_pkg::ACT_INVERSE:
            begin
                out_red_next   = div_reg[DS].rgb[0];
                out_green_next = div_reg[DS].rgb[1];
                out_blue_next  = div_reg[DS].rgb[2];
            end
            default:
            begin
                out_luma_next = '0;
            end
        endcase
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        s1_action_reg <= s1_action_next;
        s1_red_reg    <= s1_red_next;
        s1_green_reg  <= s1_green_next;
        s1_blue_reg   <= s1_blue_next;
        s1_luma_reg   <= s1_luma_next;
        s1_r_pr_reg   <= s1_r_pr_next;
        s1_g_pb_reg   <= s1_g_pb_next;
        s1_g_pr_reg   <= s1_g_pr_next;
        s1_b_pb_reg   <= s1_b_pb_next;

        s2_action_reg <= s2_action_next;
        s2_red_reg    <= s2_red_next;
        s2_blue_reg   <= s2_blue_next;
        s2_y_r_reg    <= s2_y_r_next;
        s2_y_g_reg    <= s2_y_g_next;
        s2_y_b_reg    <= s2_y_b_next;
        s2_pb_r_reg   <= s2_pb_r_next;
        s2_pb_g_reg   <= s2_pb_g_next;
        s2_pr_g_reg   <= s2_pr_g_next;
        s2_pr_b_reg   <= s2_pr_b_next;
        s2_lin_reg    <= s2_lin_next;

        s3_action_reg <= s3_action_next;
        s3_acc_reg    <= s3_acc_next;
        s3_neg_reg    <= s3_neg_next;
        s3_over_reg   <= s3_over_next;
        s3_prod_reg   <= s3_prod_next;

        for (int k = 0; k <= DS; k++)
        begin
            div_reg[k] <= div_next[k];
        end

        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
        out_luma_reg  <= out_luma_next;
        out_pb_reg    <= out_pb_next;
        out_pr_reg    <= out_pr_next;
    end

    assign done          = valid_reg[LAT-1];
    assign out_red       = out_red_reg;
    assign out_green     = out_green_reg;
    assign out_blue      = out_blue_reg;
    assign out_luma      = out_luma_reg;
    assign out_blue_diff = out_pb_reg;
    assign out_red_diff  = out_pr_reg;

    // ---------------------------------------------------------------
    // assertions

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted word did not come out after the pipeline latency");

    // one set of fields is always zero
    a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((out_red == '0) && (out_green == '0) && (out_blue == '0))
              || ((out_luma == '0) && (out_blue_diff == '0) && (out_red_diff == '0)))
        else $error("result word carries both RGB and YPbPr fields");

    // a zero max_value is stored as one, so the divisor is never zero
    a_max_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_we) |-> (max_value_reg != '0))
        else $error("max_value register holds zero");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for rgb_ypbpr_color_converter: pixel words in both directions, checked against
// a fixed-point BT.601 predictor held in a small scoreboard class. Depends on rycc_pkg.

module tb_top;

    localparam int   CHAN_W          = rycc_pkg::CHAN_W;
    localparam int   DIFF_W          = rycc_pkg::DIFF_W;
    localparam int   FRAC_BITS       = rycc_pkg::FRAC_BITS;
    localparam int   COEF_BITS       = rycc_pkg::COEF_BITS;
    localparam int   DENORM_SH       = rycc_pkg::DENORM_SH;
    localparam int   LATENCY         = rycc_pkg::LATENCY;
    localparam logic ACT_FORWARD     = rycc_pkg::ACT_FORWARD;
    localparam logic ACT_INVERSE     = rycc_pkg::ACT_INVERSE;
    localparam logic [CHAN_W-1:0] MAX_VALUE_RESET = rycc_pkg::MAX_VALUE_RESET;

    localparam int HALF_PERIOD_NS   = 5;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int PHASE_COUNT      = 8;
    localparam int DIFF_EDGES [7]   = '{-65536, 65535, -1, 0, 32767, 32768, 32769};

    typedef struct packed {
        logic                     action;
        logic        [CHAN_W-1:0] red;
        logic        [CHAN_W-1:0] green;
        logic        [CHAN_W-1:0] blue;
        logic signed [DIFF_W-1:0] luma;
        logic signed [DIFF_W-1:0] blue_diff;
        logic signed [DIFF_W-1:0] red_diff;
    } pixel_word_t;

    typedef struct packed {
        logic        [CHAN_W-1:0] red;
        logic        [CHAN_W-1:0] green;
        logic        [CHAN_W-1:0] blue;
        logic        [CHAN_W-1:0] luma;
        logic signed [CHAN_W-1:0] blue_diff;
        logic signed [CHAN_W-1:0] red_diff;
    } color_word_t;

    class pixel_scoreboard;
        logic [CHAN_W-1:0] max_value;
        color_word_t       expected_q [$];
        int                mismatches;

        function new();
            max_value  = MAX_VALUE_RESET;
            mismatches = 0;
        endfunction

        // round(acc * 2^FRAC_BITS / (m * 2^COEF_BITS)), ties away from zero
        function longint scale_to_unit(longint acc, longint m);
            longint mag;
            longint num;
            longint den;
            longint q;
            mag = (acc < 0) ? -acc : acc;
            num = mag <<< FRAC_BITS;
            den = m <<< COEF_BITS;
            q   = (2 * num + den) / (2 * den);
            return (acc < 0) ? -q : q;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // v carries FRAC_BITS + COEF_BITS fraction bits
        function longint to_channel(longint v, longint m);
            longint one;
            one = longint'(1) <<< DENORM_SH;
            if (v < 0)
                return 0;
            if (v > one)
                return m;
            return (v * m + (longint'(1) <<< (DENORM_SH - 1))) >>> DENORM_SH;
        endfunction

        function color_word_t convert(pixel_word_t p);
            color_word_t res;
            longint      m;
            longint      cr;
            longint      cg;
            longint      cb;
            longint      y;
            longint      pb;
            longint      pr;
            longint      ys;
            res = '0;
            m   = (max_value == 0) ? 1 : longint'(max_value);
            if (p.action == ACT_FORWARD)
            begin
                cr = (longint'(p.red)   > m) ? m : longint'(p.red);
                cg = (longint'(p.green) > m) ? m : longint'(p.green);
                cb = (longint'(p.blue)  > m) ? m : longint'(p.blue);
                y  = scale_to_unit(19595 * cr + 38470 * cg + 7471 * cb, m);
                pb = scale_to_unit(-11058 * cr - 21710 * cg + 32768 * cb, m);
                pr = scale_to_unit(32768 * cr - 27439 * cg - 5329 * cb, m);
                res.luma      = 16'(clip(y, 0, 65535));
                res.blue_diff = 16'(clip(pb, -32768, 32767));
                res.red_diff  = 16'(clip(pr, -32768, 32767));
            end
            else
            begin
                y  = longint'(p.luma);
                pb = longint'(p.blue_diff);
                pr = longint'(p.red_diff);
                ys = y * 65536;
                res.red   = 16'(to_channel(ys + 91881 * pr, m));
                res.green = 16'(to_channel(ys - 22554 * pb - 46802 * pr, m));
                res.blue  = 16'(to_channel(ys + 116130 * pb, m));
            end
            return res;
        endfunction

        function void note_pixel(pixel_word_t p);
            expected_q.push_back(convert(p));
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(color_word_t got);
            color_word_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word with no pixel pending");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare("out_red", want.red, got.red);
            compare("out_green", want.green, got.green);
            compare("out_blue", want.blue, got.blue);
            compare("out_luma", want.luma, got.luma);
            compare("out_blue_diff", want.blue_diff, got.blue_diff);
            compare("out_red_diff", want.red_diff, got.red_diff);
        endfunction
    endclass

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     start        = 1'b0;
    logic                     action       = ACT_FORWARD;
    logic        [CHAN_W-1:0] in_red       = '0;
    logic        [CHAN_W-1:0] in_green     = '0;
    logic        [CHAN_W-1:0] in_blue      = '0;
    logic signed [DIFF_W-1:0] in_luma      = '0;
    logic signed [DIFF_W-1:0] in_blue_diff = '0;
    logic signed [DIFF_W-1:0] in_red_diff  = '0;
    logic                     cfg_we       = 1'b0;
    logic        [CHAN_W-1:0] cfg_wdata    = '0;
    logic                     busy;
    logic                     done;
    logic        [CHAN_W-1:0] out_red;
    logic        [CHAN_W-1:0] out_green;
    logic        [CHAN_W-1:0] out_blue;
    logic        [CHAN_W-1:0] out_luma;
    logic signed [CHAN_W-1:0] out_blue_diff;
    logic signed [CHAN_W-1:0] out_red_diff;

    int              idle_cycles = 0;
    pixel_scoreboard color_board;

    rgb_ypbpr_color_converter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .in_red        (in_red),
        .in_green      (in_green),
        .in_blue       (in_blue),
        .in_luma       (in_luma),
        .in_blue_diff  (in_blue_diff),
        .in_red_diff   (in_red_diff),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .out_luma      (out_luma),
        .out_blue_diff (out_blue_diff),
        .out_red_diff  (out_red_diff)
    );

    initial
    begin
        forever #HALF_PERIOD_NS clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                color_board.max_value = cfg_wdata;
            if (start && !busy)
                color_board.note_pixel(pixel_word_t'{action, in_red, in_green, in_blue,
                                                     in_luma, in_blue_diff, in_red_diff});
            if (done)
                color_board.check_result(color_word_t'{out_red, out_green, out_blue,
                                                       out_luma, out_blue_diff,
                                                       out_red_diff});
        end
    end

    // counts cycles in which no word moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic pixel_word_t fwd(int r, int g, int b);
        pixel_word_t w;
        w        = '0;
        w.action = ACT_FORWARD;
        w.red    = 16'(r);
        w.green  = 16'(g);
        w.blue   = 16'(b);
        return w;
    endfunction

    function automatic pixel_word_t inv(int y, int pb, int pr);
        pixel_word_t w;
        w           = '0;
        w.action    = ACT_INVERSE;
        w.luma      = 17'(y);
        w.blue_diff = 17'(pb);
        w.red_diff  = 17'(pr);
        return w;
    endfunction

    function automatic logic [CHAN_W-1:0] channel_sample(logic [CHAN_W-1:0] m);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return m;
            2, 5:    return 16'($urandom_range(0, m));
            3:       return 16'($urandom);
            default: return 16'($urandom_range(m, 65535));
        endcase
    endfunction

    function automatic logic signed [DIFF_W-1:0] diff_sample(bit is_luma);
        int v;
        case ($urandom_range(0, 7))
            0:       v = DIFF_EDGES[$urandom_range(0, 6)];
            1:       v = int'($urandom_range(0, 17'h1FFFF));
            default: v = is_luma ? int'($urandom_range(0, 32768))
                                 : int'($urandom_range(0, 32768)) - 16384;
        endcase
        return 17'(v);
    endfunction

    // both field sets are filled; the unused set must not leak into the result
    function automatic pixel_word_t random_pixel(logic [CHAN_W-1:0] m);
        pixel_word_t w;
        w.action    = $urandom_range(0, 1) ? ACT_INVERSE : ACT_FORWARD;
        w.red       = channel_sample(m);
        w.green     = channel_sample(m);
        w.blue      = channel_sample(m);
        w.luma      = diff_sample(1'b1);
        w.blue_diff = diff_sample(1'b0);
        w.red_diff  = diff_sample(1'b0);
        return w;
    endfunction

    task automatic drive_pixel(pixel_word_t p);
        @(negedge clk);
        start        <= 1'b1;
        action       <= p.action;
        in_red       <= p.red;
        in_green     <= p.green;
        in_blue      <= p.blue;
        in_luma      <= p.luma;
        in_blue_diff <= p.blue_diff;
        in_red_diff  <= p.red_diff;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // start low, junk on action, in_red and in_luma
    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start        <= 1'b0;
            action       <= $urandom_range(0, 1);
            in_red       <= 16'($urandom);
            in_luma      <= 17'($urandom);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (color_board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_value(logic [CHAN_W-1:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        drive_pixel(fwd(0, 0, 0));
        drive_pixel(fwd(255, 255, 255));
        drive_pixel(fwd(65535, 65535, 65535));      // all clamped to max
        drive_pixel(fwd(255, 0, 0));
        drive_pixel(fwd(0, 255, 0));
        drive_pixel(fwd(0, 0, 255));
        drive_pixel(fwd(300, 128, 0));
        drive_pixel(fwd(1, 2, 3));
        drive_pixel(inv(32768, 0, 0));              // exactly 1.0
        drive_pixel(inv(32769, 0, 0));              // just above 1.0
        drive_pixel(inv(0, 0, 0));
        drive_pixel(inv(-1, 0, 0));                 // just below 0
        drive_pixel(inv(16384, 0, 0));              // rounding tie at max 255
        drive_pixel(inv(-65536, -65536, -65536));
        drive_pixel(inv(65535, 65535, 65535));
        drive_pixel(inv(16384, 16384, -16384));
        drive_pixel(inv(16384, -16384, 16384));
        drive_pixel(inv(1, 1, 1));
    endtask

    task automatic run_random(int count, bit with_gaps);
        int                i;
        int                gap_pct;
        logic [CHAN_W-1:0] eff_max;
        gap_pct = 0;
        eff_max = (color_board.max_value == 0) ? 16'd1 : color_board.max_value;
        for (i = 0; i < count; i++)
        begin
            // gap density changes in stretches, some with no gaps at all
            if (i % 40 == 0)
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 45;
                endcase
            if (with_gaps && $urandom_range(0, 99) < gap_pct)
                pause_sender($urandom_range(1, 17));
            drive_pixel(random_pixel(eff_max));
        end
    endtask

    initial
    begin
        logic [CHAN_W-1:0] max_plan [PHASE_COUNT];
        int                p;
        color_board = new();
        max_plan = '{16'd65535, 16'd1, 16'd0, 16'd3, 16'($urandom_range(4, 254)), 16'd1023,
                     16'($urandom_range(1024, 65534)), 16'd255};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(RANDOM_PER_PHASE, 1'b1);
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            write_max_value(max_plan[p]);
            run_random(RANDOM_PER_PHASE, p != PHASE_COUNT - 1);
        end

        wait_for_results();
        repeat (LATENCY + 10) @(posedge clk);
        if (color_board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
